[hw/rtl/limit_order_book_bbo_core_assert.svh]
// Assertion macros shared by the book core.
`ifndef LIMIT_ORDER_BOOK_BBO_CORE_ASSERT_SVH
`define LIMIT_ORDER_BOOK_BBO_CORE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define LOBB_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define LOBB_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[hw/rtl/lobb_pkg.sv]
package lobb_pkg;

  localparam int ORDER_SLOTS = 1024;
  localparam int LEVEL_SLOTS = 256;
  localparam int ORD_AW = $clog2(ORDER_SLOTS);
  localparam int LVL_AW = $clog2(LEVEL_SLOTS);
  localparam int SUM_W = 40;
  localparam int CNT_W = 11;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_MODIFY = 3'd1;
  localparam logic [2:0] CMD_CANCEL = 3'd2;
  localparam logic [2:0] CMD_TRADE  = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_ORD,
    S_RM_LV, S_RM_PRV, S_RM_NXT_RD, S_RM_NXT, S_RM_DONE,
    S_ADD_ISSUE, S_ADD_LV, S_WALK, S_INS_T_RD, S_INS_T, S_INS_P_RD, S_INS_P,
    S_ADD_WRNEW, S_ADD_ORD,
    S_MOD_LV, S_MOD_ORD,
    S_REF_ISSUE, S_REF_BID, S_REF_ASK, S_DONE
  } state_t;

  typedef struct packed {
    logic              used;
    logic [32:0]       key;
    logic [31:0]       amt;
  } ord_t;

  typedef struct packed {
    logic [32:0]       key;
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  cnt;
    logic [LVL_AW-1:0] nxt;
    logic [LVL_AW-1:0] prv;
  } lvl_t;

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [31:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W-31){1'b0}}, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] floor_sub(logic [SUM_W-1:0] a, logic [31:0] b);
    logic [SUM_W-1:0] bw;
    bw = {{(SUM_W-32){1'b0}}, b};
    return (a > bw) ? a - bw : '0;
  endfunction

  // Bids sort from the highest price down, asks from the lowest up.
  function automatic logic beats(logic sd, logic [31:0] a, logic [31:0] b);
    return sd ? (a < b) : (a > b);
  endfunction

endpackage

[hw/rtl/limit_order_book_bbo_core.sv]
// A trade goes straight to the output and leaves the book untouched; an add that opens a
// new price level beside others walks the sorted levels of its side, from the best, to its place.
// Throughput: one item at a time; the level walk over the level memory port sets the rate.
// Clear sweeps the order memory, one entry a cycle.
// Reset is synchronous; after it the whole order memory is swept, with in_stall high,
// before the first transfer.
`include "limit_order_book_bbo_core_assert.svh"

module limit_order_book_bbo_core
  import lobb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [9:0]  order_id,
  input  logic        side,
  input  logic [31:0] price,
  input  logic [31:0] qty,
  input  logic [7:0]  ticker,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        event_kind,
  output logic [7:0]  ticker_out,
  output logic [31:0] price_out,
  output logic        side_out,
  output logic        bid_valid,
  output logic [31:0] bid_price,
  output logic [39:0] bid_total,
  output logic        ask_valid,
  output logic [31:0] ask_price,
  output logic [39:0] ask_total,
  output logic [1:0]  status
);

  state_t state, state_next;

  ord_t om_mem [ORDER_SLOTS];
  lvl_t lv_mem [LEVEL_SLOTS];
  ord_t om_q, om_wdata;
  lvl_t lv_q, lv_wdata;
  logic om_re, om_we, lv_re, lv_we;
  logic [ORD_AW-1:0] om_raddr, om_waddr;
  logic [LVL_AW-1:0] lv_raddr, lv_waddr;

  logic [2:0]  cmd_r;
  logic [ORD_AW-1:0] id_r;
  logic        sd_r;
  logic [31:0] price_r, qty_r;
  logic [7:0]  ticker_r;
  logic [32:0] okey_r;
  logic [31:0] oamt_r;
  logic [LVL_AW-1:0] t_r, p_r, nxt_r, prv_r;
  logic        found_r;
  logic [1:0]  status_r;
  logic        kind_r;
  logic [1:0]  best_valid;
  logic [LVL_AW-1:0] best_slot [2];
  logic [LEVEL_SLOTS-1:0] level_used;
  logic [31:0] bid_p_r, ask_p_r;
  logic [SUM_W-1:0] bid_t_r, ask_t_r;
  logic [ORD_AW-1:0] sweep_cnt;
  logic        sweep_ref;

  logic        accept, load;
  logic [32:0] key_new;
  logic [LVL_AW-1:0] s_new, s_old, s_q;
  logic        sd_old;
  logic [CNT_W-1:0] cnt_dec;
  logic        key_hit, walk_beats;
  logic        trade_ord;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign load     = (state == S_DONE) && !(out_valid && out_stall);
  assign key_new  = {sd_r, price_r};
  assign s_new    = price_r[LVL_AW-1:0];
  assign s_old    = okey_r[LVL_AW-1:0];
  assign sd_old   = okey_r[32];
  assign s_q      = om_q.key[LVL_AW-1:0];
  assign cnt_dec  = (lv_q.cnt != '0) ? lv_q.cnt - 1'b1 : '0;
  assign key_hit  = (lv_q.key == okey_r);
  assign walk_beats = beats(sd_r, price_r, lv_q.key[31:0]);
  assign trade_ord = (state == S_ORD) && (cmd_r == CMD_TRADE);

  always_ff @(posedge clk) begin
    if (om_we) om_mem[om_waddr] <= om_wdata;
    if (om_re) om_q <= om_mem[om_raddr];
  end

  always_ff @(posedge clk) begin
    if (lv_we) lv_mem[lv_waddr] <= lv_wdata;
    if (lv_re) lv_q <= lv_mem[lv_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_SWEEP;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    om_re = 1'b0;  om_raddr = order_id[ORD_AW-1:0];
    om_we = 1'b0;  om_waddr = id_r;  om_wdata = '0;
    lv_re = 1'b0;  lv_raddr = s_new;
    lv_we = 1'b0;  lv_waddr = s_new; lv_wdata = lv_q;
    case (state)
      S_SWEEP: begin
        om_we = 1'b1;
        om_waddr = sweep_cnt;
        if (sweep_cnt == ORD_AW'(ORDER_SLOTS - 1))
          state_next = sweep_ref ? S_REF_ISSUE : S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          om_re = 1'b1;
          state_next = S_ORD;
        end
      end
      S_ORD: begin
        case (cmd_r)
          CMD_ADD, CMD_CANCEL: begin
            if (!om_q.used) begin
              state_next = (cmd_r == CMD_ADD) ? S_ADD_ISSUE : S_REF_ISSUE;
            end else if (level_used[s_q]) begin
              lv_re = 1'b1;
              lv_raddr = s_q;
              state_next = S_RM_LV;
            end else begin
              state_next = S_RM_DONE;
            end
          end
          CMD_MODIFY: begin
            if (!om_q.used) begin
              state_next = S_REF_ISSUE;
            end else if (level_used[s_q]) begin
              lv_re = 1'b1;
              lv_raddr = s_q;
              state_next = S_MOD_LV;
            end else begin
              state_next = S_MOD_ORD;
            end
          end
          CMD_TRADE: state_next = S_DONE;
          CMD_CLEAR: state_next = S_SWEEP;
          default:   state_next = S_REF_ISSUE;
        endcase
      end
      S_RM_LV: begin
        state_next = S_RM_DONE;
        if (key_hit) begin
          if (cnt_dec != '0) begin
            lv_we = 1'b1;
            lv_waddr = s_old;
            lv_wdata.sum = floor_sub(lv_q.sum, oamt_r);
            lv_wdata.cnt = cnt_dec;
          end else if (lv_q.nxt != s_old) begin
            lv_re = 1'b1;
            lv_raddr = lv_q.prv;
            state_next = S_RM_PRV;
          end
        end
      end
      S_RM_PRV: begin
        lv_we = 1'b1;
        lv_waddr = prv_r;
        lv_wdata.nxt = nxt_r;
        state_next = S_RM_NXT_RD;
      end
      S_RM_NXT_RD: begin
        lv_re = 1'b1;
        lv_raddr = nxt_r;
        state_next = S_RM_NXT;
      end
      S_RM_NXT: begin
        lv_we = 1'b1;
        lv_waddr = nxt_r;
        lv_wdata.prv = prv_r;
        state_next = S_RM_DONE;
      end
      S_RM_DONE: begin
        om_we = 1'b1;
        state_next = (cmd_r == CMD_ADD) ? S_ADD_ISSUE : S_REF_ISSUE;
      end
      S_ADD_ISSUE: begin
        if (level_used[s_new]) begin
          lv_re = 1'b1;
          state_next = S_ADD_LV;
        end else if (!best_valid[sd_r]) begin
          state_next = S_ADD_WRNEW;
        end else begin
          lv_re = 1'b1;
          lv_raddr = best_slot[sd_r];
          state_next = S_WALK;
        end
      end
      S_ADD_LV: begin
        if (lv_q.key != key_new || lv_q.cnt >= COUNT_MAX) begin
          state_next = S_REF_ISSUE;
        end else begin
          lv_we = 1'b1;
          lv_wdata.sum = sat_add(lv_q.sum, qty_r);
          lv_wdata.cnt = lv_q.cnt + 1'b1;
          state_next = S_ADD_ORD;
        end
      end
      S_WALK: begin
        if (walk_beats) begin
          lv_we = 1'b1;
          lv_waddr = t_r;
          lv_wdata.prv = s_new;
          state_next = S_INS_P_RD;
        end else if (lv_q.nxt == best_slot[sd_r]) begin
          // Wrapped around: the new level goes in at the tail, just before the best.
          state_next = S_INS_T_RD;
        end else begin
          lv_re = 1'b1;
          lv_raddr = lv_q.nxt;
        end
      end
      S_INS_T_RD: begin
        lv_re = 1'b1;
        lv_raddr = t_r;
        state_next = S_INS_T;
      end
      S_INS_T: begin
        lv_we = 1'b1;
        lv_waddr = t_r;
        lv_wdata.prv = s_new;
        state_next = S_INS_P_RD;
      end
      S_INS_P_RD: begin
        lv_re = 1'b1;
        lv_raddr = p_r;
        state_next = S_INS_P;
      end
      S_INS_P: begin
        lv_we = 1'b1;
        lv_waddr = p_r;
        lv_wdata.nxt = s_new;
        state_next = S_ADD_WRNEW;
      end
      S_ADD_WRNEW: begin
        lv_we = 1'b1;
        lv_wdata.key = key_new;
        lv_wdata.sum = {{(SUM_W-32){1'b0}}, qty_r};
        lv_wdata.cnt = CNT_W'(1);
        lv_wdata.nxt = t_r;
        lv_wdata.prv = p_r;
        state_next = S_ADD_ORD;
      end
      S_ADD_ORD: begin
        om_we = 1'b1;
        om_wdata = '{used: 1'b1, key: key_new, amt: qty_r};
        state_next = S_REF_ISSUE;
      end
      S_MOD_LV: begin
        if (key_hit) begin
          lv_we = 1'b1;
          lv_waddr = s_old;
          lv_wdata.sum = sat_add(floor_sub(lv_q.sum, oamt_r), qty_r);
        end
        state_next = S_MOD_ORD;
      end
      S_MOD_ORD: begin
        om_we = 1'b1;
        om_wdata = '{used: 1'b1, key: okey_r, amt: qty_r};
        state_next = S_REF_ISSUE;
      end
      S_REF_ISSUE: begin
        lv_re = 1'b1;
        lv_raddr = best_slot[0];
        state_next = S_REF_BID;
      end
      S_REF_BID: begin
        lv_re = 1'b1;
        lv_raddr = best_slot[1];
        state_next = S_REF_ASK;
      end
      S_REF_ASK: state_next = S_DONE;
      S_DONE: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= '0;
      best_slot[0] <= '0;
      best_slot[1] <= '0;
      level_used <= '0;
      sweep_cnt <= '0;
      sweep_ref <= 1'b0;
      bid_p_r <= '0;
      bid_t_r <= '0;
      ask_p_r <= '0;
      ask_t_r <= '0;
    end else begin
      case (state)
        S_SWEEP: sweep_cnt <= sweep_cnt + 1'b1;
        S_IDLE: begin
          if (accept) begin
            cmd_r    <= cmd;
            id_r     <= order_id[ORD_AW-1:0];
            sd_r     <= side;
            price_r  <= price;
            qty_r    <= qty;
            ticker_r <= ticker;
            status_r <= STAT_OK;
            kind_r   <= 1'b0;
          end
        end
        S_ORD: begin
          okey_r <= om_q.key;
          oamt_r <= om_q.amt;
          if (cmd_r == CMD_TRADE) kind_r <= 1'b1;
          if ((cmd_r == CMD_MODIFY || cmd_r == CMD_CANCEL) && !om_q.used)
            status_r <= STAT_UNKNOWN;
          if (cmd_r == CMD_CLEAR) begin
            level_used <= '0;
            best_valid <= '0;
            best_slot[0] <= '0;
            best_slot[1] <= '0;
            sweep_cnt <= '0;
            sweep_ref <= 1'b1;
          end
        end
        S_RM_LV: begin
          if (key_hit && cnt_dec == '0) begin
            level_used[s_old] <= 1'b0;
            if (lv_q.nxt == s_old) begin
              best_valid[sd_old] <= 1'b0;
              best_slot[sd_old] <= '0;
            end else begin
              nxt_r <= lv_q.nxt;
              prv_r <= lv_q.prv;
              if (best_valid[sd_old] && best_slot[sd_old] == s_old)
                best_slot[sd_old] <= lv_q.nxt;
            end
          end
        end
        S_ADD_ISSUE: begin
          found_r <= 1'b0;
          if (!level_used[s_new] && !best_valid[sd_r]) begin
            t_r <= s_new;
            p_r <= s_new;
          end else begin
            t_r <= best_slot[sd_r];
          end
        end
        S_ADD_LV: begin
          if (lv_q.key != key_new || lv_q.cnt >= COUNT_MAX) status_r <= STAT_FULL;
        end
        S_WALK: begin
          if (walk_beats) begin
            found_r <= 1'b1;
            p_r <= lv_q.prv;
          end else if (lv_q.nxt == best_slot[sd_r]) begin
            t_r <= best_slot[sd_r];
          end else begin
            t_r <= lv_q.nxt;
          end
        end
        S_INS_T: p_r <= lv_q.prv;
        S_ADD_WRNEW: begin
          level_used[s_new] <= 1'b1;
          if (!best_valid[sd_r]) begin
            best_valid[sd_r] <= 1'b1;
            best_slot[sd_r] <= s_new;
          end else if (found_r && t_r == best_slot[sd_r]) begin
            best_slot[sd_r] <= s_new;
          end
        end
        S_REF_BID: begin
          bid_p_r <= best_valid[0] ? lv_q.key[31:0] : '0;
          bid_t_r <= best_valid[0] ? lv_q.sum : '0;
        end
        S_REF_ASK: begin
          ask_p_r <= best_valid[1] ? lv_q.key[31:0] : '0;
          ask_t_r <= best_valid[1] ? lv_q.sum : '0;
        end
        default: ;
      endcase
    end
  end

  // Output register: the next item may start while this result waits for its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_kind <= kind_r;
      ticker_out <= ticker_r;
      price_out  <= price_r;
      side_out   <= sd_r;
      bid_valid  <= best_valid[0];
      bid_price  <= bid_p_r;
      bid_total  <= bid_t_r;
      ask_valid  <= best_valid[1];
      ask_price  <= ask_p_r;
      ask_total  <= ask_t_r;
      status     <= status_r;
    end
  end

  `LOBB_ASSERT_ALWAYS(a_no_rw_clash, !(lv_re && lv_we) || (lv_raddr != lv_waddr), "rw clash")
  `LOBB_ASSERT_ALWAYS(a_bid_level_used, !best_valid[0] || level_used[best_slot[0]], "bid free")
  `LOBB_ASSERT_ALWAYS(a_ask_level_used, !best_valid[1] || level_used[best_slot[1]], "ask free")
  `LOBB_ASSERT_NEXT(a_trade_skips_book, trade_ord, state == S_DONE, "trade touched the book")

endmodule
